/* hdl/lmv_pkg.sv */
// Shared types and constants for the label majority vote core.
// Depends on nothing; used by the lane, merge and top-level modules.
package lmv_pkg;

  // Widest voter set the block supports.
  localparam int unsigned MaxVoters = 8;
  localparam int unsigned LabelW    = 8;
  localparam int unsigned ClassW    = 9;
  localparam int unsigned WinnerW   = 9;
  // Wide enough to hold a vote count of MaxVoters.
  localparam int unsigned CountW    = 4;

  // Class count after reset: every label takes part.
  localparam logic [ClassW-1:0]  ClassCountReset = 9'd256;
  // Winner code for a tie or for no counted vote (-1).
  localparam logic [WinnerW-1:0] WinnerNone      = 9'h1FF;

  // What one lane found: its voter's label and the votes that label got.
  typedef struct packed {
    logic [LabelW-1:0] label;
    logic [CountW-1:0] count;
  } lane_res_t;

endpackage

/* hdl/lmv_lane.sv */
// One vote-counting lane: counts how many counted voters share its voter's label.
// Depends on lmv_pkg for widths and the lane result type.
module lmv_lane #(
  parameter int unsigned NUM_VOTERS = 8,
  parameter int unsigned LANE       = 0
) (
  input  logic                                     clk_i,
  input  logic [NUM_VOTERS-1:0][lmv_pkg::LabelW-1:0] labels_i,
  input  logic [NUM_VOTERS-1:0]                    counted_i,
  output lmv_pkg::lane_res_t                       res_o
);

  logic [lmv_pkg::CountW-1:0] count_d;
  lmv_pkg::lane_res_t         res_q;

  // Count the counted voters whose label matches this lane's label.
  always_comb begin
    count_d = '0;
    if (counted_i[LANE]) begin
      for (int unsigned j = 0; j < NUM_VOTERS; j++) begin
        if (counted_i[j] && (labels_i[j] == labels_i[LANE])) begin
          count_d = count_d + lmv_pkg::CountW'(1);
        end
      end
    end
  end

  // Lane result register.
  always_ff @(posedge clk_i) begin
    res_q.label <= labels_i[LANE];
    res_q.count <= count_d;
  end

  assign res_o = res_q;

endmodule

/* hdl/lmv_merge.sv */
// Merging stage: finds the largest lane count and decides winner or tie.
// Depends on lmv_pkg for widths, constants and the lane result type.
module lmv_merge #(
  parameter int unsigned NUM_VOTERS = 8
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    valid_i,
  input  lmv_pkg::lane_res_t [NUM_VOTERS-1:0]     res_i,
  output logic                                    done_o,
  output logic signed [lmv_pkg::WinnerW-1:0]      winner_o
);

  logic [lmv_pkg::CountW-1:0]             max_d;
  logic [lmv_pkg::CountW-1:0]             max_q;
  lmv_pkg::lane_res_t [NUM_VOTERS-1:0]    res_q;
  logic                                   valid_a_q;

  logic [NUM_VOTERS-1:0]                  hit;
  logic [lmv_pkg::CountW-1:0]             hit_cnt;
  logic [lmv_pkg::LabelW-1:0]             pick_label;
  logic                                   found;
  logic [lmv_pkg::WinnerW-1:0]            winner_d;
  logic [lmv_pkg::WinnerW-1:0]            winner_q;
  logic                                   done_q;

  // Largest vote count over all lanes.
  always_comb begin
    max_d = '0;
    for (int unsigned v = 0; v < NUM_VOTERS; v++) begin
      if (res_i[v].count > max_d) begin
        max_d = res_i[v].count;
      end
    end
  end

  // First merge register: lane results and their maximum.
  always_ff @(posedge clk_i) begin
    res_q <= res_i;
    max_q <= max_d;
  end

  // Lanes holding the maximum. The winning class owns exactly max_q lanes,
  // so any other lane at the maximum means a second class ties with it.
  always_comb begin
    hit_cnt    = '0;
    pick_label = '0;
    found      = 1'b0;
    for (int unsigned v = 0; v < NUM_VOTERS; v++) begin
      hit[v] = (res_q[v].count == max_q);
      if (hit[v]) begin
        hit_cnt = hit_cnt + lmv_pkg::CountW'(1);
        if (!found) begin
          pick_label = res_q[v].label;
          found      = 1'b1;
        end
      end
    end
    if ((max_q != '0) && (hit_cnt == max_q)) begin
      winner_d = {1'b0, pick_label};
    end else begin
      winner_d = lmv_pkg::WinnerNone;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    winner_q <= winner_d;
  end

  // Strobe pipeline through the two merge registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      valid_a_q <= valid_i;
      done_q    <= valid_a_q;
    end
  end

  assign done_o   = done_q;
  assign winner_o = $signed(winner_q);

endmodule

/* hdl/label_majority_vote_core.sv */
// Top level of the label majority vote core: class count register, vote lanes, merge.
// Depends on lmv_pkg, lmv_lane and lmv_merge.
//
//   Channel   Handshake            Payload
//   request   start_i / busy_o     label_0_i .. label_7_i, valid_mask_i
//   result    done_o (strobe)      winner_o
//   config    cfg_we_i             cfg_wdata_i (class count)
//
// One request is taken every cycle; busy_o is always low.
// Each result passes the lane result register, then the first merge register and
// the result register of the merging stage, before it shows on done_o.
// Reset clears the strobe pipeline and sets the class count to 256.
// The receiver cannot stall; each result is shown for one cycle only.
module label_majority_vote_core #(
  parameter int unsigned NUM_VOTERS = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic [lmv_pkg::LabelW-1:0]           label_0_i,
  input  logic [lmv_pkg::LabelW-1:0]           label_1_i,
  input  logic [lmv_pkg::LabelW-1:0]           label_2_i,
  input  logic [lmv_pkg::LabelW-1:0]           label_3_i,
  input  logic [lmv_pkg::LabelW-1:0]           label_4_i,
  input  logic [lmv_pkg::LabelW-1:0]           label_5_i,
  input  logic [lmv_pkg::LabelW-1:0]           label_6_i,
  input  logic [lmv_pkg::LabelW-1:0]           label_7_i,
  input  logic [lmv_pkg::MaxVoters-1:0]        valid_mask_i,
  input  logic                                 cfg_we_i,
  input  logic [lmv_pkg::ClassW-1:0]           cfg_wdata_i,
  output logic                                 done_o,
  output logic signed [lmv_pkg::WinnerW-1:0]   winner_o
);

  logic [lmv_pkg::ClassW-1:0]                        class_count_q;
  logic [lmv_pkg::MaxVoters-1:0][lmv_pkg::LabelW-1:0] all_labels;
  logic [NUM_VOTERS-1:0][lmv_pkg::LabelW-1:0]        labels;
  logic [NUM_VOTERS-1:0]                             counted;
  lmv_pkg::lane_res_t [NUM_VOTERS-1:0]               lane_res;
  logic                                              accept;
  logic                                              lane_valid_q;

  // The block never holds a request off.
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // Class count register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      class_count_q <= lmv_pkg::ClassCountReset;
    end else if (cfg_we_i) begin
      class_count_q <= cfg_wdata_i;
    end
  end

  assign all_labels = {label_7_i, label_6_i, label_5_i, label_4_i,
                       label_3_i, label_2_i, label_1_i, label_0_i};

  // A voter counts when it is valid and its label lies below the class count.
  for (genvar v = 0; v < NUM_VOTERS; v++) begin : g_vote
    assign labels[v]  = all_labels[v];
    assign counted[v] = valid_mask_i[v] && ({1'b0, labels[v]} < class_count_q);

    lmv_lane #(
      .NUM_VOTERS (NUM_VOTERS),
      .LANE       (v)
    ) u_lane (
      .clk_i     (clk_i),
      .labels_i  (labels),
      .counted_i (counted),
      .res_o     (lane_res[v])
    );
  end

  // Strobe alongside the lane registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_valid_q <= 1'b0;
    end else begin
      lane_valid_q <= accept;
    end
  end

  lmv_merge #(
    .NUM_VOTERS (NUM_VOTERS)
  ) u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (lane_valid_q),
    .res_i    (lane_res),
    .done_o   (done_o),
    .winner_o (winner_o)
  );

endmodule
